// ----- rtl/core/first_fit_heap_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator
// Implication forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define FFHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ffha assertion failed");

// Next-cycle implication, disabled while reset is applied.
`define FFHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ffha assertion failed");

`endif

// ----- rtl/core/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Types, codes and width helpers shared by the heap allocator files.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int HEAP_BYTES_DEF   = 4096;
	localparam int HEADER_BYTES_DEF = 8;
	localparam int MIN_BLOCK        = 12;
	localparam int ADDR_W           = 13;

	localparam logic [1:0] FN_ALLOC  = 2'd0;
	localparam logic [1:0] FN_FREE   = 2'd1;
	localparam logic [1:0] FN_SHRINK = 2'd2;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	typedef struct packed {
		logic [1:0]        func;
		logic [15:0]       request_size;
		logic [ADDR_W-1:0] payload_address;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] result_address;
	} result_t;

	typedef struct packed {
		logic nxt;
		logic prv;
		logic used;
	} ram_we_t;

	function automatic int val_width(input int heap);
		return $clog2(heap + 1);
	endfunction

	function automatic int slot_width(input int heap);
		return $clog2((heap >> 2) + 2);
	endfunction

endpackage

// ----- rtl/core/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a chain of block headers with free-block merging.
// ----------------------------------------------------------------------------
// Channel   Handshake           Payload
// command   start, busy         cmd    (func, request_size, payload_address)
// result    done (one cycle)    result (status, result_address)
//
// After reset a clearing pass writes all HEAP_BYTES/4 + 2 header slots, one per cycle.
// A command refused at once goes straight to the response state. Allocate walks the
// header chain from the lowest-free pointer, splits the block when the rest is large,
// and moves the lowest-free pointer past used headers when it took the block there.
// Free and shrink check headers and merge free neighbours, one header access per cycle.
// The result word is flagged by done for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
	parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
	parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ffha_pkg::cmd_t    cmd,
	output logic              done,
	output ffha_pkg::result_t result
);

	localparam int AW    = ffha_pkg::val_width(HEAP_BYTES);
	localparam int SW    = ffha_pkg::slot_width(HEAP_BYTES);
	localparam int SLOTS = (HEAP_BYTES >> 2) + 2;

	logic [SW-1:0]     raddr;
	logic [SW-1:0]     waddr;
	logic [AW-1:0]     rd_next;
	logic [AW-1:0]     rd_prev;
	logic              rd_used;
	logic [AW-1:0]     wnext;
	logic [AW-1:0]     wprev;
	logic              wused;
	ffha_pkg::ram_we_t we;

	ffha_seq #(
		.HEAP_BYTES   (HEAP_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.done    (done),
		.result  (result),
		.raddr   (raddr),
		.rd_next (rd_next),
		.rd_prev (rd_prev),
		.rd_used (rd_used),
		.waddr   (waddr),
		.we      (we),
		.wnext   (wnext),
		.wprev   (wprev),
		.wused   (wused)
	);

	ffha_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_next_ram (
		.clk   (clk),
		.we    (we.nxt),
		.waddr (waddr),
		.wdata (wnext),
		.raddr (raddr),
		.rdata (rd_next)
	);

	ffha_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_prev_ram (
		.clk   (clk),
		.we    (we.prv),
		.waddr (waddr),
		.wdata (wprev),
		.raddr (raddr),
		.rdata (rd_prev)
	);

	ffha_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_used_ram (
		.clk   (clk),
		.we    (we.used),
		.waddr (waddr),
		.wdata (wused),
		.raddr (raddr),
		.rdata (rd_used)
	);

endmodule

// ----- rtl/core/ffha_ram.sv -----
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/ffha_seq.sv -----
// ----------------------------------------------------------------------------
// ffha_seq
// Sequencer that walks and edits the block header chain one access per cycle.
// ----------------------------------------------------------------------------
module ffha_seq #(
	parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
	parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
	localparam int AW = ffha_pkg::val_width(HEAP_BYTES),
	localparam int SW = ffha_pkg::slot_width(HEAP_BYTES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ffha_pkg::cmd_t    cmd,
	output logic              done,
	output ffha_pkg::result_t result,
	output logic [SW-1:0]     raddr,
	input  logic [AW-1:0]     rd_next,
	input  logic [AW-1:0]     rd_prev,
	input  logic              rd_used,
	output logic [SW-1:0]     waddr,
	output ffha_pkg::ram_we_t we,
	output logic [AW-1:0]     wnext,
	output logic [AW-1:0]     wprev,
	output logic              wused
);

	localparam int AD      = ffha_pkg::ADDR_W;
	localparam int END_SL  = (HEAP_BYTES >> 2) + 1;
	localparam int HDR     = ((HEADER_BYTES + 3) >> 2) << 2;
	localparam int CW      = ((AW > AD) ? AW : AD) + 2;
	localparam logic [AW-1:0] HEAP_A = AW'(HEAP_BYTES);
	localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);
	localparam logic [CW-1:0] HDR_C  = CW'(HDR);
	localparam logic [CW-1:0] MIN_C  = CW'(ffha_pkg::MIN_BLOCK);
	localparam logic [SW-1:0] END_S  = SW'(END_SL);

	typedef enum logic [30:0] {
		S_CLR    = 31'd1 << 0,
		S_IDLE   = 31'd1 << 1,
		S_RESP   = 31'd1 << 2,
		S_A_RD   = 31'd1 << 3,
		S_A_CHK  = 31'd1 << 4,
		S_SP1    = 31'd1 << 5,
		S_SP2    = 31'd1 << 6,
		S_SP3    = 31'd1 << 7,
		S_SP_END = 31'd1 << 8,
		S_A_MARK = 31'd1 << 9,
		S_ADV_RD = 31'd1 << 10,
		S_ADV_CK = 31'd1 << 11,
		S_V_RD1  = 31'd1 << 12,
		S_V_CK1  = 31'd1 << 13,
		S_V_RD2  = 31'd1 << 14,
		S_V_CK2  = 31'd1 << 15,
		S_V_Q    = 31'd1 << 16,
		S_V_CK3  = 31'd1 << 17,
		S_V_OK   = 31'd1 << 18,
		S_MG_RD1 = 31'd1 << 19,
		S_MG_CK1 = 31'd1 << 20,
		S_MG_RD2 = 31'd1 << 21,
		S_MG_CK2 = 31'd1 << 22,
		S_MG_W1  = 31'd1 << 23,
		S_MG_W2  = 31'd1 << 24,
		S_MG_RD3 = 31'd1 << 25,
		S_MG_CK3 = 31'd1 << 26,
		S_MG_RD4 = 31'd1 << 27,
		S_MG_CK4 = 31'd1 << 28,
		S_MG_W3  = 31'd1 << 29,
		S_MG_W4  = 31'd1 << 30
	} state_t;

	state_t            state_q;
	logic [SW-1:0]     clr_q;
	logic [1:0]        func_q;
	logic [AW-1:0]     size_q;
	logic [AD-1:0]     addr_q;
	logic [AW-1:0]     p_q;
	logic [AW-1:0]     n_q;
	logic [AW-1:0]     q_q;
	logic [AW-1:0]     m_q;
	logic [AW-1:0]     lf_q;
	logic [1:0]        st_q;
	logic [AD-1:0]     ra_q;
	logic              done_q;
	ffha_pkg::result_t result_q;

	logic [16:0]   rnd;
	logic          size_ok;
	logic [CW-1:0] ax;
	logic          addr_ok;
	logic [CW-1:0] pc;
	logic [CW-1:0] nc;
	logic [CW-1:0] sc;
	logic [CW-1:0] rnc;
	logic          fit;
	logic          split_a;
	logic          split_s;

	function automatic logic [SW-1:0] slot(input logic [AW-1:0] x);
		if (x >= HEAP_A) begin
			return END_S;
		end
		return SW'(x >> 2);
	endfunction

	assign rnd     = (17'(cmd.request_size) + 17'd3) & 17'h1FFFC;
	assign size_ok = (rnd >= 17'(ffha_pkg::MIN_BLOCK)) && (rnd <= 17'(HEAP_BYTES));
	assign ax      = CW'(cmd.payload_address);
	assign addr_ok = (ax >= HDR_C) && (ax < HEAP_C) && (cmd.payload_address[1:0] == 2'b00);
	assign pc      = CW'(p_q);
	assign nc      = CW'(n_q);
	assign sc      = CW'(size_q);
	assign rnc     = CW'(rd_next);
	assign fit     = !rd_used && (rnc >= pc + HDR_C + sc);
	assign split_a = rnc >= pc + HDR_C + HDR_C + sc + MIN_C;
	assign split_s = pc + sc + HDR_C + HDR_C + MIN_C < nc;

	always_comb begin
		raddr = '0;
		unique case (state_q)
			S_A_RD:   raddr = slot(p_q);
			S_A_CHK:  raddr = slot(rd_next);
			S_ADV_RD: raddr = slot(lf_q);
			S_ADV_CK: raddr = slot(rd_next);
			S_V_RD1:  raddr = slot(p_q);
			S_V_RD2:  raddr = slot(n_q);
			S_V_Q:    raddr = slot(q_q);
			S_MG_RD1: raddr = slot(m_q);
			S_MG_RD2: raddr = slot(n_q);
			S_MG_RD3: raddr = slot(m_q);
			S_MG_RD4: raddr = slot(q_q);
			default:  raddr = '0;
		endcase
	end

	always_comb begin
		waddr = '0;
		we    = '0;
		wnext = '0;
		wprev = '0;
		wused = 1'b0;
		unique case (state_q)
			S_CLR: begin
				waddr = clr_q;
				we    = '{nxt: 1'b1, prv: 1'b1, used: 1'b1};
				wnext = ((clr_q == '0) || (clr_q == END_S)) ? HEAP_A : '0;
				wprev = (clr_q == END_S) ? HEAP_A : '0;
				wused = (clr_q == END_S);
			end
			S_SP1: begin
				waddr = slot(m_q);
				we    = '{nxt: 1'b1, prv: 1'b1, used: 1'b1};
				wnext = n_q;
				wprev = p_q;
			end
			S_SP2: begin
				waddr  = slot(p_q);
				we.nxt = 1'b1;
				wnext  = m_q;
			end
			S_SP3: begin
				waddr  = slot(n_q);
				we.prv = 1'b1;
				wprev  = m_q;
			end
			S_A_MARK: begin
				waddr   = slot(p_q);
				we.used = 1'b1;
				wused   = 1'b1;
			end
			S_V_OK: begin
				waddr   = slot(p_q);
				we.used = (func_q == ffha_pkg::FN_FREE);
			end
			S_MG_W1: begin
				waddr  = slot(m_q);
				we.nxt = 1'b1;
				wnext  = n_q;
			end
			S_MG_W2: begin
				waddr  = slot(n_q);
				we.prv = 1'b1;
				wprev  = m_q;
			end
			S_MG_W3: begin
				waddr  = slot(q_q);
				we.nxt = 1'b1;
				wnext  = n_q;
			end
			S_MG_W4: begin
				waddr  = slot(n_q);
				we.prv = 1'b1;
				wprev  = q_q;
			end
			default: begin
				waddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			lf_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					if (clr_q == END_S) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (start) begin
						func_q  <= cmd.func;
						size_q  <= AW'(rnd);
						addr_q  <= cmd.payload_address;
						p_q     <= AW'(ax - HDR_C);
						state_q <= S_RESP;
						st_q    <= ffha_pkg::ST_REFUSED;
						ra_q    <= '0;
						unique case (cmd.func)
							ffha_pkg::FN_ALLOC: begin
								if (size_ok) begin
									p_q     <= lf_q;
									state_q <= S_A_RD;
								end
							end
							ffha_pkg::FN_FREE: begin
								if (addr_ok) begin
									state_q <= S_V_RD1;
								end else begin
									st_q <= ffha_pkg::ST_IGNORED;
									ra_q <= cmd.payload_address;
								end
							end
							ffha_pkg::FN_SHRINK: begin
								if (size_ok && addr_ok) begin
									state_q <= S_V_RD1;
								end else if (size_ok) begin
									st_q <= ffha_pkg::ST_IGNORED;
									ra_q <= cmd.payload_address;
								end
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_RESP: begin
					done_q                  <= 1'b1;
					result_q.status         <= st_q;
					result_q.result_address <= ra_q;
					state_q                 <= S_IDLE;
				end
				S_A_RD: begin
					if (p_q >= HEAP_A) begin
						st_q    <= ffha_pkg::ST_REFUSED;
						ra_q    <= '0;
						state_q <= S_RESP;
					end else begin
						state_q <= S_A_CHK;
					end
				end
				S_A_CHK: begin
					if (rd_next <= p_q) begin
						st_q    <= ffha_pkg::ST_REFUSED;
						ra_q    <= '0;
						state_q <= S_RESP;
					end else if (fit) begin
						n_q     <= rd_next;
						m_q     <= AW'(pc + HDR_C + sc);
						state_q <= split_a ? S_SP1 : S_A_MARK;
					end else begin
						p_q <= rd_next;
						if (rd_next >= HEAP_A) begin
							st_q    <= ffha_pkg::ST_REFUSED;
							ra_q    <= '0;
							state_q <= S_RESP;
						end
					end
				end
				S_SP1: begin
					state_q <= S_SP2;
				end
				S_SP2: begin
					state_q <= (n_q != HEAP_A) ? S_SP3 : S_SP_END;
				end
				S_SP3: begin
					state_q <= S_SP_END;
				end
				S_SP_END: begin
					if (func_q == ffha_pkg::FN_ALLOC) begin
						state_q <= S_A_MARK;
					end else begin
						if (m_q < lf_q) begin
							lf_q <= m_q;
						end
						state_q <= S_MG_RD1;
					end
				end
				S_A_MARK: begin
					st_q    <= ffha_pkg::ST_DONE;
					ra_q    <= AD'(pc + HDR_C);
					state_q <= (p_q == lf_q) ? S_ADV_RD : S_RESP;
				end
				S_ADV_RD: begin
					state_q <= S_ADV_CK;
				end
				S_ADV_CK: begin
					if (rd_used && (lf_q < HEAP_A)) begin
						if (rd_next <= lf_q) begin
							lf_q    <= HEAP_A;
							state_q <= S_RESP;
						end else begin
							lf_q <= rd_next;
							if (rd_next >= HEAP_A) begin
								state_q <= S_RESP;
							end
						end
					end else begin
						state_q <= S_RESP;
					end
				end
				S_V_RD1: begin
					state_q <= S_V_CK1;
				end
				S_V_CK1: begin
					n_q <= rd_next;
					q_q <= rd_prev;
					if ((rd_next <= p_q) || (rd_next > HEAP_A)) begin
						st_q    <= ffha_pkg::ST_IGNORED;
						ra_q    <= addr_q;
						state_q <= S_RESP;
					end else begin
						state_q <= (rd_next != HEAP_A) ? S_V_RD2 : S_V_Q;
					end
				end
				S_V_RD2: begin
					state_q <= S_V_CK2;
				end
				S_V_CK2: begin
					if (rd_prev != p_q) begin
						st_q    <= ffha_pkg::ST_IGNORED;
						ra_q    <= addr_q;
						state_q <= S_RESP;
					end else begin
						state_q <= S_V_Q;
					end
				end
				S_V_Q: begin
					if (p_q == '0) begin
						state_q <= S_V_OK;
					end else if (q_q >= p_q) begin
						st_q    <= ffha_pkg::ST_IGNORED;
						ra_q    <= addr_q;
						state_q <= S_RESP;
					end else begin
						state_q <= S_V_CK3;
					end
				end
				S_V_CK3: begin
					if (rd_next != p_q) begin
						st_q    <= ffha_pkg::ST_IGNORED;
						ra_q    <= addr_q;
						state_q <= S_RESP;
					end else begin
						state_q <= S_V_OK;
					end
				end
				S_V_OK: begin
					st_q <= ffha_pkg::ST_DONE;
					ra_q <= addr_q;
					if (func_q == ffha_pkg::FN_FREE) begin
						if (p_q < lf_q) begin
							lf_q <= p_q;
						end
						m_q     <= p_q;
						state_q <= S_MG_RD1;
					end else if (split_s) begin
						m_q     <= AW'(pc + HDR_C + sc);
						state_q <= S_SP1;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_MG_RD1: begin
					state_q <= S_MG_CK1;
				end
				S_MG_CK1: begin
					n_q     <= rd_next;
					state_q <= S_MG_RD2;
				end
				S_MG_RD2: begin
					state_q <= S_MG_CK2;
				end
				S_MG_CK2: begin
					if ((n_q != m_q) && !rd_used && (n_q != HEAP_A)) begin
						if (lf_q == n_q) begin
							lf_q <= m_q;
						end
						n_q     <= rd_next;
						state_q <= S_MG_W1;
					end else begin
						state_q <= S_MG_RD3;
					end
				end
				S_MG_W1: begin
					state_q <= S_MG_W2;
				end
				S_MG_W2: begin
					state_q <= S_MG_RD3;
				end
				S_MG_RD3: begin
					state_q <= S_MG_CK3;
				end
				S_MG_CK3: begin
					q_q     <= rd_prev;
					n_q     <= rd_next;
					state_q <= S_MG_RD4;
				end
				S_MG_RD4: begin
					state_q <= S_MG_CK4;
				end
				S_MG_CK4: begin
					if ((q_q != m_q) && !rd_used) begin
						if (lf_q == m_q) begin
							lf_q <= q_q;
						end
						state_q <= S_MG_W3;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_MG_W3: begin
					state_q <= S_MG_W4;
				end
				S_MG_W4: begin
					state_q <= S_RESP;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- rtl/core/ffha_checker.sv -----
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks on command acceptance and result words.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_assert.svh"

module ffha_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input ffha_pkg::result_t result
);

	logic refused;

	assign refused = done && (result.status == ffha_pkg::ST_REFUSED);

	`FFHA_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`FFHA_ASSERT_NXT(a_done_single, clk, arst_n, done, !done)
	`FFHA_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`FFHA_ASSERT_IMP(a_refused_zero, clk, arst_n, refused, result.result_address == '0)

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);
